/* src/owu_pkg.sv */
package owu_pkg;

   localparam int FRAC = 24;
   localparam int DW = 32;
   localparam int AW = 31;

   localparam logic [2:0] MODE_SGD      = 3'd0;
   localparam logic [2:0] MODE_MOMENTUM = 3'd1;
   localparam logic [2:0] MODE_ADAGRAD  = 3'd2;
   localparam logic [2:0] MODE_RMSPROP  = 3'd3;
   localparam logic [2:0] MODE_RMSMOM   = 3'd4;

   localparam logic [2:0] REG_MODE      = 3'd0;
   localparam logic [2:0] REG_LR        = 3'd1;
   localparam logic [2:0] REG_WD        = 3'd2;
   localparam logic [2:0] REG_MF        = 3'd3;
   localparam logic [2:0] REG_SMOOTH    = 3'd4;
   localparam logic [2:0] REG_SCALE     = 3'd5;

   localparam logic [24:0] ONE_Q = 25'd16777216;

   // The radicand r*2^24 is below 2^55; it is padded to an even 56 bits and its
   // root fits in 28 bits.
   localparam int ROOT_W = 28;
   localparam int RAD_W = 2 * ROOT_W;
   // Magnitude of lr*g is below 2^62.
   localparam int MAG_W = 63;
   // Quotient bits produced by the divider; a larger quotient is flagged as overflow.
   localparam int QUO_W = 32;
   localparam int FIFO_DEPTH = 4;

   typedef struct packed {
      logic [2:0]  mode;
      logic [30:0] learn_rate;
      logic [30:0] weight_decay;
      logic [24:0] momentum_factor;
      logic [24:0] smoothing;
      logic [24:0] grad_scale;
   } cfg_type;

   // Item handed from the front part to the back part.
   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] weight;
      logic signed [31:0] grad;
      logic signed [31:0] velocity;
      logic [30:0]        sq_accum;
      logic               last;
   } item_type;

   // Q8.24 product rounded to nearest, ties up: floor((p + half) / 2^24).
   function automatic logic signed [63:0] qround(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + 64'sd8388608;
      return t >>> FRAC;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic [30:0] satu31(input logic signed [63:0] v);
      if (v < 64'sd0) return 31'd0;
      if (v > 64'sd2147483647) return 31'h7fffffff;
      return v[30:0];
   endfunction

endpackage

/* src/owu_csr.sv */
module owu_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [4:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output owu_pkg::cfg_type     cfg
);

   owu_pkg::cfg_type cfg_ff;
   logic wr_en;
   logic [2:0] idx;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign idx = csr_paddr[4:2];
   assign cfg = cfg_ff;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= owu_pkg::MODE_SGD;
         cfg_ff.learn_rate <= 31'd167772;
         cfg_ff.weight_decay <= 31'd0;
         cfg_ff.momentum_factor <= 25'd15099494;
         cfg_ff.smoothing <= 25'd15099494;
         cfg_ff.grad_scale <= 25'd16777216;
      end else if (wr_en) begin
         case (idx)
            owu_pkg::REG_MODE:   cfg_ff.mode <= csr_pwdata[2:0];
            owu_pkg::REG_LR:     cfg_ff.learn_rate <= csr_pwdata[30:0];
            owu_pkg::REG_WD:     cfg_ff.weight_decay <= csr_pwdata[30:0];
            owu_pkg::REG_MF:     cfg_ff.momentum_factor <= csr_pwdata[24:0];
            owu_pkg::REG_SMOOTH: cfg_ff.smoothing <= csr_pwdata[24:0];
            owu_pkg::REG_SCALE:  cfg_ff.grad_scale <= csr_pwdata[24:0];
            default: ;
         endcase
      end
   end

   // Read back.
   always_comb begin
      case (idx)
         owu_pkg::REG_MODE:   csr_prdata = {29'd0, cfg_ff.mode};
         owu_pkg::REG_LR:     csr_prdata = {1'b0, cfg_ff.learn_rate};
         owu_pkg::REG_WD:     csr_prdata = {1'b0, cfg_ff.weight_decay};
         owu_pkg::REG_MF:     csr_prdata = {7'd0, cfg_ff.momentum_factor};
         owu_pkg::REG_SMOOTH: csr_prdata = {7'd0, cfg_ff.smoothing};
         owu_pkg::REG_SCALE:  csr_prdata = {7'd0, cfg_ff.grad_scale};
         default:             csr_prdata = 32'd0;
      endcase
   end

endmodule

/* src/owu_front.sv */
// Front part: scales the gradient and adds weight decay, two stages.
module owu_front (
   input  logic                 clock,
   input  logic                 reset,
   input  owu_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  owu_pkg::item_type    in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output owu_pkg::item_type    out_item
);

   logic s1_valid_ff, s2_valid_ff;
   owu_pkg::item_type s1_item_ff, s2_item_ff;
   owu_pkg::item_type s1_item_in, s2_item_in;
   logic signed [63:0] wd_prod_ff;
   logic s1_ready, s2_ready;
   logic signed [31:0] g_scaled;
   logic signed [63:0] wd_q;

   assign s2_ready = ~s2_valid_ff | out_ready;
   assign s1_ready = ~s1_valid_ff | s2_ready;
   assign in_ready = s1_ready;
   assign out_valid = s2_valid_ff;
   assign out_item = s2_item_ff;

   assign g_scaled = owu_pkg::sat32(owu_pkg::qround(
      64'(in_item.grad) * $signed({39'd0, cfg.grad_scale})));

   always_comb begin
      s1_item_in = in_item;
      s1_item_in.mode = cfg.mode;
      s1_item_in.grad = g_scaled;
   end

   // Stage one: scaled gradient and decay product.
   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (s1_ready) s1_valid_ff <= in_valid;
      if (s1_ready && in_valid) begin
         s1_item_ff <= s1_item_in;
         wd_prod_ff <= owu_pkg::qround(
            64'(in_item.weight) * $signed({33'd0, cfg.weight_decay}));
      end
   end

   // The decay product is kept at full width so that only the sum saturates.
   assign wd_q = 64'(s1_item_ff.grad) + wd_prod_ff;

   always_comb begin
      s2_item_in = s1_item_ff;
      if (cfg.weight_decay != 31'd0) s2_item_in.grad = owu_pkg::sat32(wd_q);
   end

   // Stage two: decayed gradient.
   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (s2_ready) s2_valid_ff <= s1_valid_ff;
      if (s2_ready && s1_valid_ff) s2_item_ff <= s2_item_in;
   end

endmodule

/* src/owu_fifo.sv */
module owu_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   output logic                 wr_ready,
   input  owu_pkg::item_type    wr_item,
   output logic                 rd_valid,
   input  logic                 rd_ready,
   output owu_pkg::item_type    rd_item
);

   localparam int PW = $clog2(owu_pkg::FIFO_DEPTH);
   owu_pkg::item_type mem_ff [owu_pkg::FIFO_DEPTH];
   logic [PW-1:0] wp_ff, rp_ff;
   logic [PW:0] cnt_ff;
   logic push, pop;

   assign wr_ready = cnt_ff != (PW+1)'(owu_pkg::FIFO_DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_item = mem_ff[rp_ff];
   assign push = wr_valid & wr_ready;
   assign pop = rd_valid & rd_ready;

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wr_item;
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(owu_pkg::FIFO_DEPTH))
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> !pop)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("push not counted");

endmodule

/* src/owu_back.sv */
// Back part: accumulator update, square root, divide and final sums.
// A fixed pipeline; one item may enter every cycle unless the last stage is held.
module owu_back (
   input  logic                 clock,
   input  logic                 reset,
   input  owu_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  owu_pkg::item_type    in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic signed [31:0]   weight_out,
   output logic signed [31:0]   velocity_out,
   output logic [30:0]          sq_accum_out,
   output logic                 last_out
);

   localparam int RS = owu_pkg::ROOT_W;   // root steps
   localparam int DS = owu_pkg::QUO_W + 1; // divide setup plus one stage per quotient bit
   localparam int NS = 4 + RS + DS + 2;   // total stages

   typedef struct packed {
      owu_pkg::item_type    it;
      logic signed [63:0]   prod;     // lr * g
      logic [owu_pkg::MAG_W-1:0] mag; // |lr * g|
      logic signed [63:0]   vm;       // qmul(v, mf)
      logic signed [63:0]   plain;    // qmul(lr, g)
      logic signed [63:0]   t0;
      logic signed [63:0]   t1;
      logic [owu_pkg::ROOT_W:0]   rem;
      logic [owu_pkg::RAD_W-1:0]  rad;
      logic [owu_pkg::ROOT_W-1:0] root;
      logic [owu_pkg::MAG_W:0]    num;
      logic                       ovf;
      logic [owu_pkg::QUO_W-1:0]  quo;
      logic signed [31:0]   step;
   } st_type;

   st_type st_ff [NS];
   logic   vld_ff [NS];
   logic   adv;
   logic [24:0] s_cl;

   // The whole pipe moves together; it stalls only when the last stage is held.
   assign adv = ~vld_ff[NS-1] | out_ready;
   assign in_ready = adv;
   assign out_valid = vld_ff[NS-1];
   assign weight_out = st_ff[NS-1].it.weight;
   assign velocity_out = st_ff[NS-1].it.velocity;
   assign sq_accum_out = st_ff[NS-1].it.sq_accum;
   assign last_out = st_ff[NS-1].it.last;

   assign s_cl = (cfg.smoothing > owu_pkg::ONE_Q) ? owu_pkg::ONE_Q : cfg.smoothing;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < NS; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_type b;
         logic [1:0] pair;
         logic [owu_pkg::ROOT_W+3:0] trial;
         logic [owu_pkg::ROOT_W+1:0] dtr;
         logic [owu_pkg::ROOT_W:0]   den;
         logic [owu_pkg::QUO_W:0]    q;
         // Stage 0: products of the item.
         b = '0;
         b.it = in_item;
         b.prod = 64'(in_item.grad) * $signed({33'd0, cfg.learn_rate});
         b.t0 = 64'(in_item.grad) * 64'(in_item.grad);
         b.t1 = 64'(in_item.velocity) * $signed({39'd0, cfg.momentum_factor});
         st_ff[0] <= b;

         // Stage 1: g2, vm, plain step, |lr*g|, r*s.
         b = st_ff[0];
         b.vm = owu_pkg::qround(b.t1);
         b.plain = owu_pkg::qround(b.prod);
         b.mag = b.prod[63] ? owu_pkg::MAG_W'(-b.prod) : b.prod[owu_pkg::MAG_W-1:0];
         b.t1 = 64'(owu_pkg::satu31(owu_pkg::qround(b.t0)));
         b.t0 = $signed({33'd0, b.it.sq_accum}) * $signed({39'd0, s_cl});
         st_ff[1] <= b;

         // Stage 2: (1-s)*g2 and accumulator sums.
         b = st_ff[1];
         if (b.it.mode == owu_pkg::MODE_ADAGRAD) begin
            b.t0 = 64'(owu_pkg::satu31(64'(b.it.sq_accum) + b.t1));
         end else begin
            b.t0 = owu_pkg::qround(b.t0);
            b.t1 = $signed({33'd0, b.t1[30:0]}) * $signed({39'd0, owu_pkg::ONE_Q - s_cl});
         end
         st_ff[2] <= b;

         // Stage 3: new accumulator, radicand.
         b = st_ff[2];
         if (b.it.mode == owu_pkg::MODE_RMSPROP || b.it.mode == owu_pkg::MODE_RMSMOM)
            b.it.sq_accum = owu_pkg::satu31(b.t0 + owu_pkg::qround(b.t1));
         else if (b.it.mode == owu_pkg::MODE_ADAGRAD)
            b.it.sq_accum = b.t0[30:0];
         b.rad = {1'b0, b.it.sq_accum, 24'd0};
         b.rem = '0;
         b.root = '0;
         st_ff[3] <= b;

         // Square root, one result bit per stage from two radicand bits.
         for (int k = 0; k < RS; k++) begin
            b = st_ff[3+k];
            pair = b.rad[owu_pkg::RAD_W-1 - 2*k -: 2];
            trial = {1'b0, b.rem, pair} - {2'b00, b.root, 2'b01};
            if (!trial[owu_pkg::ROOT_W+3]) begin
               b.rem = trial[owu_pkg::ROOT_W:0];
               b.root = {b.root[owu_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               b.rem = {b.rem[owu_pkg::ROOT_W-2:0], pair};
               b.root = {b.root[owu_pkg::ROOT_W-2:0], 1'b0};
            end
            st_ff[4+k] <= b;
         end

         // Divide setup: numerator 2*mag + root; a quotient of 2^32 or more is overflow.
         b = st_ff[3+RS];
         den = {b.root, 1'b0};
         b.num = {b.mag, 1'b0} + (owu_pkg::MAG_W+1)'(b.root);
         b.ovf = b.num[owu_pkg::MAG_W:owu_pkg::QUO_W]
                 >= (owu_pkg::MAG_W+1-owu_pkg::QUO_W)'(den);
         b.rem = b.num[owu_pkg::QUO_W+owu_pkg::ROOT_W:owu_pkg::QUO_W];
         b.num = {b.num[owu_pkg::QUO_W-1:0], owu_pkg::QUO_W'(0)};
         b.quo = '0;
         st_ff[4+RS] <= b;

         // Restoring divide of the low numerator bits by 2*root.
         for (int k = 1; k < DS; k++) begin
            b = st_ff[3+RS+k];
            den = {b.root, 1'b0};
            dtr = {b.rem, b.num[owu_pkg::MAG_W]};
            b.num = {b.num[owu_pkg::MAG_W-1:0], 1'b0};
            if (dtr >= {1'b0, den}) begin
               b.rem = (owu_pkg::ROOT_W+1)'(dtr - {1'b0, den});
               b.quo = {b.quo[owu_pkg::QUO_W-2:0], 1'b1};
            end else begin
               b.rem = dtr[owu_pkg::ROOT_W:0];
               b.quo = {b.quo[owu_pkg::QUO_W-2:0], 1'b0};
            end
            st_ff[4+RS+k] <= b;
         end

         // Clamp and sign the divided step; momentum velocity.
         b = st_ff[NS-3];
         q = {1'b0, b.quo};
         if (b.ovf || q > 33'd2147483648) q = 33'd2147483648;
         if (b.it.sq_accum == 31'd0)
            b.step = 32'sd0;
         else
            b.step = owu_pkg::sat32(b.prod[63] ? -$signed(64'(q)) : $signed(64'(q)));
         if (b.it.mode == owu_pkg::MODE_MOMENTUM)
            b.it.velocity = owu_pkg::sat32(b.vm - b.plain);
         st_ff[NS-2] <= b;

         // Final weight and velocity sums.
         b = st_ff[NS-2];
         case (b.it.mode)
            owu_pkg::MODE_SGD: begin
               b.it.weight = owu_pkg::sat32(64'(b.it.weight) - b.plain);
            end
            owu_pkg::MODE_MOMENTUM: begin
               b.it.weight = owu_pkg::sat32(64'(b.it.weight) + 64'(b.it.velocity));
            end
            owu_pkg::MODE_ADAGRAD, owu_pkg::MODE_RMSPROP: begin
               b.it.weight = owu_pkg::sat32(64'(b.it.weight) - 64'(b.step));
            end
            owu_pkg::MODE_RMSMOM: begin
               b.it.velocity = owu_pkg::sat32(b.vm - 64'(b.step));
               b.it.weight = owu_pkg::sat32(64'(b.it.weight) + 64'(b.it.velocity));
            end
            default: ;
         endcase
         st_ff[NS-1] <= b;
      end
   end

endmodule

/* src/optimizer_weight_update.sv */
// Channel  | Direction | Contents
// req_     | in        | tdata: weight_in, gradient_in, velocity_in, sq_accum_in; tlast
// rsp_     | out       | tdata: weight_out, velocity_out, sq_accum_out; tlast
// csr_     | in/out    | APB registers at byte address 4*i
// One request is accepted every cycle unless a held result has filled the queue;
// latency is set by the square root and divide stages. A result passes 2 front stages,
// the queue and 67 back stages (4 setup, 28 root, 33 divide, 2 final).
// Reset is synchronous and clears valid flags, queue pointers and configuration registers.
// A stalled result holds the back pipeline; the queue lets the front keep taking requests.
module optimizer_weight_update (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // weight_in [31:0], gradient_in [63:32], velocity_in [95:64], sq_accum_in [126:96]
   input  logic [127:0]  req_tdata,
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // weight_out [31:0], velocity_out [63:32], sq_accum_out [94:64]
   output logic [95:0]   rsp_tdata,
   output logic          rsp_tlast,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [4:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);
   owu_pkg::cfg_type cfg;
   owu_pkg::item_type req_item, f_item, q_item;
   logic f_valid, f_ready, q_valid, q_ready;
   logic signed [31:0] w_o, v_o;
   logic [30:0] r_o;

   owu_csr u_csr (.clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg);

   always_comb begin
      req_item.mode = cfg.mode;
      req_item.weight = req_tdata[31:0];
      req_item.grad = req_tdata[63:32];
      req_item.velocity = req_tdata[95:64];
      req_item.sq_accum = req_tdata[126:96];
      req_item.last = req_tlast;
   end

   owu_front u_front (.clock, .reset, .cfg, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_item(req_item), .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item));

   owu_fifo u_fifo (.clock, .reset, .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item));

   owu_back u_back (.clock, .reset, .cfg, .in_valid(q_valid), .in_ready(q_ready),
      .in_item(q_item), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .weight_out(w_o), .velocity_out(v_o), .sq_accum_out(r_o), .last_out(rsp_tlast));

   assign rsp_tdata = {1'b0, r_o, v_o, w_o};

endmodule
